// ----- rtl/core/gbnp_pkg.sv -----
// Shared types and constants for the grid bucket nearest point search.
`timescale 1ns / 1ps

package gbnp_pkg;

    localparam int GRID_SIDE_DEF    = 10;
    localparam int BUCKET_DEPTH_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;

    localparam int TOL_W      = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int CELL_OUT_W = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DUP_TOL = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_FOUND    = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_CELL,
        S_CNT,
        S_DECIDE,
        S_SQX,
        S_SQY,
        S_ACC,
        S_RESULT
    } state_t;

endpackage

// ----- rtl/core/grid_bucket_nearest_point.sv -----
// Grid bucket nearest point search: clear, insert and nearest query over a uniform grid.
// s_ready is low while a word is worked on, so no new word is taken before the last result is
// registered; a stalled m_ready holds the result state.
// One shared squarer does dx*dx and dy*dy in turn for each scanned slot.
// A query scans only the bucket of its own cell and stops early at a point within tolerance.
// Synchronous active-low reset empties all cells and sets dup_tolerance to 16.
`timescale 1ns / 1ps

module grid_bucket_nearest_point #(
    parameter int GRID_SIDE    = gbnp_pkg::GRID_SIDE_DEF,
    parameter int BUCKET_DEPTH = gbnp_pkg::BUCKET_DEPTH_DEF,
    parameter int COORD_BITS   = gbnp_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gbnp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gbnp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gbnp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gbnp_pkg::CMD_W-1:0]          s_cmd,
    input  logic [COORD_BITS:0]                 s_x_coord,
    input  logic [COORD_BITS:0]                 s_y_coord,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gbnp_pkg::STATUS_W-1:0]       m_status,
    output logic [COORD_BITS:0]                 m_near_x,
    output logic [COORD_BITS:0]                 m_near_y,
    output logic [gbnp_pkg::SLOT_OUT_W-1:0]     m_slot,
    output logic [gbnp_pkg::CELL_OUT_W-1:0]     m_cell_res
);
    import gbnp_pkg::*;

    localparam int W           = COORD_BITS + 1;
    localparam int NCELLS      = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W      = $clog2(NCELLS);
    localparam int GI_W        = $clog2(GRID_SIDE);
    localparam int GS_W        = $clog2(GRID_SIDE + 1);
    localparam int PROD_W      = W + GS_W;
    localparam int STORE_DEPTH = NCELLS * BUCKET_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int SQ_IN_W     = (W > TOL_W) ? W : TOL_W;
    localparam int SQ_W        = 2 * SQ_IN_W;
    localparam int SUM_W       = SQ_W + 1;

    state_t                 state_reg, state_next;
    logic [TOL_W-1:0]       tol_reg;

    cmd_t                   cmd_reg;
    logic [W-1:0]           x_reg, y_reg;
    logic [W-1:0]           prev_x_reg, prev_y_reg;
    logic                   prev_valid_reg;
    logic                   dup_reg;
    logic [GI_W-1:0]        row_reg, col_reg;
    logic [CELL_W-1:0]      cell_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [CNT_W-1:0]       cnt_q_reg;
    logic [CNT_W-1:0]       i_reg;
    logic [SQ_W-1:0]        tol2_reg;
    logic [SQ_W-1:0]        sq_x_reg, sq_y_reg;
    logic [SUM_W-1:0]       best_reg;

    logic [NCELLS-1:0]      valid_reg;
    logic [CNT_W-1:0]       cnt_mem [NCELLS];
    logic [2*W-1:0]         store_mem [STORE_DEPTH];
    logic [2*W-1:0]         store_rd_reg;

    status_t                res_status_reg;
    logic [W-1:0]           res_x_reg, res_y_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic [CELL_W-1:0]      res_cell_reg;

    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [W-1:0]           m_near_x_reg, m_near_y_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic [CELL_W-1:0]      m_cell_reg;

    logic                   s_accept;
    logic                   out_free;
    logic                   store_we, store_re, cnt_we;
    logic [SLOT_W-1:0]      rd_slot;
    logic [ADDR_W-1:0]      rd_addr, wr_addr;
    logic [W-1:0]           rd_x, rd_y;
    logic [SQ_IN_W-1:0]     sq_in;
    logic [SQ_W-1:0]        sq_out;
    logic [PROD_W-1:0]      prod_x, prod_y;
    logic [W-1:0]           dup_dx, dup_dy;
    logic [SUM_W-1:0]       d_sum, bd_new;
    logic                   take;
    logic [CNT_W-1:0]       i_next;
    logic                   go_on;
    logic                   cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_DUP_TOL);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_DUP_TOL)
                    ? APB_DATA_W'(tol_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr) begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    // shared squarer
    assign rd_x = store_rd_reg[2*W-1:W];
    assign rd_y = store_rd_reg[W-1:0];

    always_comb begin
        unique case (state_reg)
            S_HASH:  sq_in = SQ_IN_W'(tol_reg);
            S_SQX:   sq_in = SQ_IN_W'((rd_x > x_reg) ? rd_x - x_reg : x_reg - rd_x);
            S_SQY:   sq_in = SQ_IN_W'((rd_y > y_reg) ? rd_y - y_reg : y_reg - rd_y);
            default: sq_in = '0;
        endcase
    end

    assign sq_out = SQ_W'(sq_in) * SQ_W'(sq_in);

    // hash and duplicate check
    assign prod_x = PROD_W'(x_reg) * PROD_W'(GRID_SIDE);
    assign prod_y = PROD_W'(y_reg) * PROD_W'(GRID_SIDE);
    assign dup_dx = (x_reg > prev_x_reg) ? x_reg - prev_x_reg : prev_x_reg - x_reg;
    assign dup_dy = (y_reg > prev_y_reg) ? y_reg - prev_y_reg : prev_y_reg - y_reg;

    // scan compare
    assign d_sum  = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg);
    assign take   = (i_reg == '0) || (d_sum < best_reg);
    assign bd_new = take ? d_sum : best_reg;
    assign i_next = CNT_W'(i_reg + 1'b1);
    assign go_on  = (i_next < cnt_q_reg) && (bd_new > SUM_W'(tol2_reg));

    assign rd_slot = (state_reg == S_ACC) ? i_next[SLOT_W-1:0] : '0;
    assign rd_addr = base_reg + ADDR_W'(rd_slot);
    assign wr_addr = base_reg + ADDR_W'(cnt_q_reg[SLOT_W-1:0]);

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        store_we   = 1'b0;
        store_re   = 1'b0;
        cnt_we     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_cmd != CMD_NONE)) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                state_next = (cmd_reg == CMD_CLEAR) ? S_RESULT : S_CELL;
            end
            S_CELL: begin
                state_next = S_CNT;
            end
            S_CNT: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (cmd_reg == CMD_INSERT) begin
                    state_next = S_RESULT;
                    if (!dup_reg && (cnt_q_reg < CNT_W'(BUCKET_DEPTH))) begin
                        store_we = 1'b1;
                        cnt_we   = 1'b1;
                    end
                end else if (cnt_q_reg == '0) begin
                    state_next = S_RESULT;
                end else begin
                    store_re   = 1'b1;
                    state_next = S_SQX;
                end
            end
            S_SQX: begin
                state_next = S_SQY;
            end
            S_SQY: begin
                state_next = S_ACC;
            end
            S_ACC: begin
                if (go_on) begin
                    store_re   = 1'b1;
                    state_next = S_SQX;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // bucket store and cell counts
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[wr_addr] <= {x_reg, y_reg};
        end
        if (store_re) begin
            store_rd_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cell_reg] <= CNT_W'(cnt_q_reg + 1'b1);
        end
        if (state_reg == S_CNT) begin
            cnt_q_reg <= valid_reg[cell_reg] ? cnt_mem[cell_reg] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            prev_valid_reg <= 1'b0;
        end else if ((state_reg == S_HASH) && (cmd_reg == CMD_CLEAR)) begin
            valid_reg      <= '0;
            prev_valid_reg <= 1'b0;
        end else if ((state_reg == S_DECIDE) && (cmd_reg == CMD_INSERT)) begin
            prev_valid_reg <= 1'b1;
            if (cnt_we) begin
                valid_reg[cell_reg] <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd_reg        <= cmd_t'(s_cmd);
                    x_reg          <= s_x_coord;
                    y_reg          <= s_y_coord;
                    res_status_reg <= ST_CLEARED;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_slot_reg   <= '0;
                    res_cell_reg   <= '0;
                end
            end
            S_HASH: begin
                row_reg  <= x_reg[COORD_BITS] ? GI_W'(GRID_SIDE - 1)
                                              : GI_W'(prod_x >> COORD_BITS);
                col_reg  <= y_reg[COORD_BITS] ? GI_W'(GRID_SIDE - 1)
                                              : GI_W'(prod_y >> COORD_BITS);
                dup_reg  <= prev_valid_reg
                            && (SQ_IN_W'(dup_dx) < SQ_IN_W'(tol_reg))
                            && (SQ_IN_W'(dup_dy) < SQ_IN_W'(tol_reg));
                tol2_reg <= sq_out;
            end
            S_CELL: begin
                cell_reg     <= CELL_W'(CELL_W'(row_reg) * CELL_W'(GRID_SIDE)
                                        + CELL_W'(col_reg));
                res_cell_reg <= CELL_W'(CELL_W'(row_reg) * CELL_W'(GRID_SIDE)
                                        + CELL_W'(col_reg));
            end
            S_CNT: begin
                base_reg <= ADDR_W'(ADDR_W'(cell_reg) * ADDR_W'(BUCKET_DEPTH));
                i_reg    <= '0;
            end
            S_DECIDE: begin
                if (cmd_reg == CMD_INSERT) begin
                    prev_x_reg <= x_reg;
                    prev_y_reg <= y_reg;
                    if (dup_reg) begin
                        res_status_reg <= ST_DUP;
                    end else if (cnt_q_reg >= CNT_W'(BUCKET_DEPTH)) begin
                        res_status_reg <= ST_FULL;
                    end else begin
                        res_status_reg <= ST_INSERTED;
                        res_slot_reg   <= cnt_q_reg[SLOT_W-1:0];
                    end
                end else if (cnt_q_reg == '0) begin
                    res_status_reg <= ST_EMPTY;
                end else begin
                    res_status_reg <= ST_FOUND;
                end
            end
            S_SQX: begin
                sq_x_reg <= sq_out;
            end
            S_SQY: begin
                sq_y_reg <= sq_out;
            end
            S_ACC: begin
                best_reg <= bd_new;
                i_reg    <= i_next;
                if (take) begin
                    res_x_reg    <= rd_x;
                    res_y_reg    <= rd_y;
                    res_slot_reg <= i_reg[SLOT_W-1:0];
                end
            end
            S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_RESULT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_RESULT) && out_free) begin
            m_status_reg <= res_status_reg;
            m_near_x_reg <= res_x_reg;
            m_near_y_reg <= res_y_reg;
            m_slot_reg   <= res_slot_reg;
            m_cell_reg   <= res_cell_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_near_x   = m_near_x_reg;
    assign m_near_y   = m_near_y_reg;
    assign m_slot     = SLOT_OUT_W'(m_slot_reg);
    assign m_cell_res = CELL_OUT_W'(m_cell_reg);

    a_store_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |-> (cnt_q_reg < CNT_W'(BUCKET_DEPTH)))
        else $error("store write into a full bucket");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SQX) || (state_reg == S_SQY) || (state_reg == S_ACC))
        |-> (i_reg < cnt_q_reg))
        else $error("scan index beyond cell count");

    a_found_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_RESULT) && (res_status_reg == ST_FOUND))
        |-> (CNT_W'(res_slot_reg) < cnt_q_reg))
        else $error("found slot beyond cell count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd != CMD_NONE)) |=> !s_ready)
        else $error("ready while a word is in work");

endmodule

// ----- sim/grid_bucket_nearest_point_tb.sv -----
// Self-checking testbench for the grid bucket nearest point search with directed words and random traffic.
`timescale 1ns / 1ps

module grid_bucket_nearest_point_tb;
    import gbnp_pkg::*;

    localparam int SIDE   = GRID_SIDE_DEF;
    localparam int DEPTH  = BUCKET_DEPTH_DEF;
    localparam int CBITS  = COORD_BITS_DEF;
    localparam int NCELL  = SIDE * SIDE;
    localparam int ONE    = 1 << CBITS;
    localparam int CMAX   = (2 << CBITS) - 1;
    localparam int SETTLE = 8 + 3 * DEPTH + 16;
    localparam int LIMIT  = 1000000;
    localparam logic [APB_ADDR_W-1:0] TOL_ADDR = {REG_DUP_TOL, 2'b00};

    typedef logic [CBITS:0] coord_t;

    typedef struct packed {
        status_t               status;
        coord_t                near_x;
        coord_t                near_y;
        logic [SLOT_OUT_W-1:0] slot;
        logic [CELL_OUT_W-1:0] cell_no;
    } reply_t;

    class bucket_grid_shadow;
        coord_t           pt_x [NCELL][DEPTH];
        coord_t           pt_y [NCELL][DEPTH];
        int unsigned      fill [NCELL];
        coord_t           last_x;
        coord_t           last_y;
        bit               last_valid;
        logic [TOL_W-1:0] tol;
        reply_t           replies_due [$];
        int unsigned      failures;
        int unsigned      checked;
        int unsigned      by_status [6];

        function new();
            foreach (fill[k]) fill[k] = 0;
            foreach (by_status[k]) by_status[k] = 0;
            last_x = '0;
            last_y = '0;
            last_valid = 1'b0;
            tol = TOL_RESET;
            failures = 0;
            checked = 0;
        endfunction

        function int unsigned axis_bin(coord_t c);
            longint unsigned g;
            if (c >= ONE) return SIDE - 1;
            g = (longint'(c) * SIDE) >> CBITS;
            return (g > SIDE - 1) ? SIDE - 1 : int'(g);
        endfunction

        function longint unsigned gap_of(coord_t a, coord_t b);
            return (a > b) ? a - b : b - a;
        endfunction

        function longint unsigned span_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
            longint unsigned dx, dy;
            dx = gap_of(ax, bx);
            dy = gap_of(ay, by);
            return dx * dx + dy * dy;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function void apply_command(cmd_t cmd, coord_t x, coord_t y);
            reply_t          r;
            int unsigned     cell_idx, n, best, i;
            longint unsigned bd, d, tol2;
            if (cmd == CMD_NONE) return;
            r = '0;
            cell_idx = axis_bin(x) * SIDE + axis_bin(y);
            case (cmd)
                CMD_CLEAR: begin
                    foreach (fill[k]) fill[k] = 0;
                    last_valid = 1'b0;
                    r.status = ST_CLEARED;
                end
                CMD_INSERT: begin
                    r.cell_no = CELL_OUT_W'(cell_idx);
                    if (last_valid && gap_of(x, last_x) < tol && gap_of(y, last_y) < tol) begin
                        r.status = ST_DUP;
                    end else if (fill[cell_idx] >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        pt_x[cell_idx][fill[cell_idx]] = x;
                        pt_y[cell_idx][fill[cell_idx]] = y;
                        r.slot = SLOT_OUT_W'(fill[cell_idx]);
                        fill[cell_idx]++;
                        r.status = ST_INSERTED;
                    end
                    last_x = x;
                    last_y = y;
                    last_valid = 1'b1;
                end
                CMD_QUERY: begin
                    r.cell_no = CELL_OUT_W'(cell_idx);
                    n = fill[cell_idx];
                    if (n == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        tol2 = tol;
                        tol2 = tol2 * tol2;
                        best = 0;
                        bd = span_sq(pt_x[cell_idx][0], pt_y[cell_idx][0], x, y);
                        for (i = 1; i < n && bd > tol2; i++) begin
                            d = span_sq(pt_x[cell_idx][i], pt_y[cell_idx][i], x, y);
                            if (d < bd) begin
                                bd = d;
                                best = i;
                            end
                        end
                        r.status = ST_FOUND;
                        r.near_x = pt_x[cell_idx][best];
                        r.near_y = pt_y[cell_idx][best];
                        r.slot = SLOT_OUT_W'(best);
                    end
                end
                default: ;
            endcase
            by_status[r.status]++;
            replies_due.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0) begin
                note_failure($sformatf("unexpected word: status %0d near (%0d,%0d) slot %0d cell %0d",
                    got.status, got.near_x, got.near_y, got.slot, got.cell_no));
                return;
            end
            want = replies_due.pop_front();
            checked++;
            if (got.status !== want.status || got.near_x !== want.near_x ||
                    got.near_y !== want.near_y || got.slot !== want.slot ||
                    got.cell_no !== want.cell_no) begin
                note_failure($sformatf(
                    "word %0d: expected status %0d near (%0d,%0d) slot %0d cell %0d, got %0d (%0d,%0d) %0d %0d",
                    checked, want.status, want.near_x, want.near_y, want.slot, want.cell_no,
                    got.status, got.near_x, got.near_y, got.slot, got.cell_no));
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd     = '0;
    coord_t                s_x_coord = '0;
    coord_t                s_y_coord = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    coord_t                m_near_x;
    coord_t                m_near_y;
    logic [SLOT_OUT_W-1:0] m_slot;
    logic [CELL_OUT_W-1:0] m_cell_res;

    bucket_grid_shadow shadow;
    int unsigned       calm_in       = 0;
    int unsigned       calm_out      = 0;
    int unsigned       cycle_count   = 0;
    int unsigned       words_sent    = 0;
    int unsigned       settings_used = 1;
    coord_t            recent_x [$];
    coord_t            recent_y [$];

    grid_bucket_nearest_point i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_x_coord  (s_x_coord),
        .s_y_coord  (s_y_coord),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_near_x   (m_near_x),
        .m_near_y   (m_near_y),
        .m_slot     (m_slot),
        .m_cell_res (m_cell_res)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("grid_bucket_nearest_point_tb NOT OK");
            $finish;
        end
    end

    function automatic coord_t coord_in(int unsigned bin);
        int unsigned lo, hi;
        lo = (bin * ONE + SIDE - 1) / SIDE;
        hi = ((bin + 1) * ONE - 1) / SIDE;
        if (bin == SIDE - 1 && $urandom_range(3, 0) == 0) begin
            return coord_t'($urandom_range(CMAX, ONE));
        end
        return coord_t'($urandom_range(hi, lo));
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(CMAX, 0));
    endfunction

    function automatic coord_t jitter(coord_t v, int unsigned spread);
        int s;
        s = int'(v) + int'($urandom_range(2 * spread, 0)) - int'(spread);
        if (s < 0) s = 0;
        if (s > CMAX) s = CMAX;
        return coord_t'(s);
    endfunction

    task automatic send_word(input cmd_t cmd, input coord_t x, input coord_t y);
        int unsigned gap;
        if (calm_in == 0 && $urandom_range(39, 0) == 0) calm_in = $urandom_range(60, 20);
        if (calm_in > 0) begin
            calm_in--;
            gap = 0;
        end else begin
            gap = $urandom_range(5, 0);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_x_coord <= x;
        s_y_coord <= y;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        shadow.apply_command(cmd, x, y);
        if (cmd != CMD_NONE) words_sent++;
        if (cmd == CMD_INSERT) begin
            recent_x.push_back(x);
            recent_y.push_back(y);
            if (recent_x.size() > 32) begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
        end
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (shadow.replies_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        wait_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOL_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.tol = value;
        settings_used++;
    endtask

    task automatic run_traffic(input int unsigned quota);
        int unsigned stop, kind, pick, k, n, spread;
        int unsigned hot_row [4];
        int unsigned hot_col [4];
        cmd_t        cmd;
        stop = words_sent + quota;
        foreach (hot_row[i]) begin
            hot_row[i] = $urandom_range(SIDE - 1, 0);
            hot_col[i] = $urandom_range(SIDE - 1, 0);
        end
        spread = (shadow.tol < 2000) ? shadow.tol + 2 : 2000;
        while (words_sent < stop) begin
            kind = $urandom_range(99, 0);
            k = $urandom_range(3, 0);
            if (kind < 5) begin
                send_word(CMD_CLEAR, any_coord(), any_coord());
            end else if (kind < 12) begin
                cmd = cmd_t'($urandom_range(3, 0));
                send_word(cmd, any_coord(), any_coord());
            end else if (kind < 22) begin
                repeat ($urandom_range(DEPTH + 4, DEPTH - 4))
                    send_word(CMD_INSERT, coord_in(hot_row[k]), coord_in(hot_col[k]));
                repeat (4) send_word(CMD_QUERY, coord_in(hot_row[k]), coord_in(hot_col[k]));
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    pick = $urandom_range(99, 0);
                    if (pick < 55) begin
                        send_word(CMD_INSERT, coord_in(hot_row[k]), coord_in(hot_col[k]));
                    end else if (pick < 70 && recent_x.size() > 0) begin
                        send_word(CMD_INSERT, jitter(recent_x[$], spread),
                            jitter(recent_y[$], spread));
                    end else if (pick < 85 || recent_x.size() == 0) begin
                        send_word(CMD_QUERY, coord_in(hot_row[k]), coord_in(hot_col[k]));
                    end else begin
                        n = $urandom_range(recent_x.size() - 1, 0);
                        send_word(CMD_QUERY, jitter(recent_x[n], spread / 2),
                            jitter(recent_y[n], spread / 2));
                    end
                end
            end
        end
    endtask

    initial begin : reply_sink
        int unsigned stall;
        reply_t      got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (calm_out == 0 && $urandom_range(39, 0) == 0) calm_out = $urandom_range(60, 20);
            if (calm_out > 0) begin
                calm_out--;
                stall = 0;
            end else begin
                stall = $urandom_range(5, 0);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            got.status  = status_t'(m_status);
            got.near_x  = m_near_x;
            got.near_y  = m_near_y;
            got.slot    = m_slot;
            got.cell_no = m_cell_res;
            shadow.check_reply(got);
        end
    end

    initial begin
        shadow = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(CMD_QUERY, coord_t'(0), coord_t'(0));
        send_word(CMD_INSERT, coord_t'(0), coord_t'(0));
        send_word(CMD_INSERT, coord_t'(0), coord_t'(0));
        send_word(CMD_INSERT, coord_t'(16), coord_t'(0));
        send_word(CMD_INSERT, coord_t'(15), coord_t'(15));
        send_word(CMD_INSERT, coord_t'(1000), coord_t'(1000));
        send_word(CMD_INSERT, coord_t'(1000), coord_t'(3000));
        send_word(CMD_QUERY, coord_t'(1000), coord_t'(2000));
        send_word(CMD_QUERY, coord_t'(8), coord_t'(0));
        send_word(CMD_INSERT, coord_t'(ONE), coord_t'(ONE));
        send_word(CMD_INSERT, coord_t'(CMAX), coord_t'(CMAX));
        send_word(CMD_INSERT, coord_t'(ONE - 1), coord_t'(0));
        send_word(CMD_INSERT, coord_t'(0), coord_t'(ONE - 1));
        send_word(CMD_QUERY, coord_t'(CMAX), coord_t'(CMAX));
        send_word(CMD_QUERY, coord_t'(ONE), coord_t'(0));
        send_word(CMD_NONE, coord_t'(CMAX), coord_t'(CMAX));
        send_word(CMD_CLEAR, coord_t'(0), coord_t'(0));
        send_word(CMD_QUERY, coord_t'(0), coord_t'(0));
        send_word(CMD_INSERT, coord_t'(0), coord_t'(0));

        run_traffic(330);
        write_tolerance('0);
        run_traffic(330);
        write_tolerance(TOL_W'($urandom_range(4095, 64)));
        run_traffic(330);
        write_tolerance('1);
        run_traffic(100);
        write_tolerance(TOL_W'(1));
        run_traffic(330);
        write_tolerance(TOL_RESET);
        run_traffic(330);
        wait_quiet();

        $display("%0d words checked over %0d tolerance settings: %0d cleared, %0d inserted",
            shadow.checked, settings_used, shadow.by_status[ST_CLEARED],
            shadow.by_status[ST_INSERTED]);
        $display("%0d duplicates skipped, %0d bucket full, %0d found, %0d empty, %0d failures",
            shadow.by_status[ST_DUP], shadow.by_status[ST_FULL], shadow.by_status[ST_FOUND],
            shadow.by_status[ST_EMPTY], shadow.failures);
        if (shadow.failures == 0) begin
            $display("grid_bucket_nearest_point_tb OK");
        end else begin
            $display("grid_bucket_nearest_point_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/gbnp_pkg.sv
rtl/core/grid_bucket_nearest_point.sv
sim/grid_bucket_nearest_point_tb.sv
